/* sv/qst_pkg.sv */
package qst_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 128;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_LBRACK = 8'd91;
  localparam logic [7:0] CH_RBRACK = 8'd93;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_DOUBLE = 2'd1,
    QM_SINGLE = 2'd2,
    QM_ODD    = 2'd3
  } quote_mode_t;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_CLOSE  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch_out;
    logic       truncated;
    logic       last;
  } event_t;

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_TAB || c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA ||
           c == CH_COLON || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_LBRACE || c == CH_RBRACE;
  endfunction

endpackage

/* sv/quoted_string_tokenizer.sv */
// Channel | Direction | tdata       | tuser                     | tlast
// s_*     | in        | [7:0] ch    | -                         | -
// m_*     | out       | [7:0] ch_out| [0] kind, [1] truncated   | last
//
// One input byte is decoded per cycle while s_tready is high, into 0..3 events that land in a
// 4-entry output queue; the queue drains one event per cycle while m_tready is high.
// s_tready is high while the queue holds at most one event, so bytes that
// make one event each flow at one per cycle; a 3-event byte stalls the input until the queue drains.
// rst (synchronous, active high) clears tokenizer state and empties the queue.
// A stalled m_tready backs up the queue, which drops s_tready, so decode state waits too.
module quoted_string_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] ch_out
  output logic [1:0] m_tuser,   // [0] kind, [1] truncated
  output logic       m_tlast
);

  qst_pkg::quote_mode_t quote_mode, quote_mode_next;
  logic [7:0] token_length, token_length_next;
  logic       overflowed, overflowed_next;

  qst_pkg::event_t               slots [qst_pkg::QDEPTH];
  qst_pkg::event_t               slots_next [qst_pkg::QDEPTH];
  logic [qst_pkg::QCNT_W-1:0]    count, count_next;

  qst_pkg::event_t ev [3];
  logic [1:0]      n_ev;

  logic push, pop;
  logic lead_v, app_v, trail_v;
  logic lead_trunc, trail_trunc;
  logic in_str, is_q, dropped;
  logic [7:0] q_char;

  assign s_tready = count <= qst_pkg::QCNT_W'(1);
  assign m_tvalid = count != '0;
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  assign m_tdata    = slots[0].ch_out;
  assign m_tuser[0] = slots[0].kind;
  assign m_tuser[1] = slots[0].truncated;
  assign m_tlast    = slots[0].last;

  // decode: optional leading close, optional append, optional trailing close
  always_comb begin
    logic [1:0] pos;
    in_str  = quote_mode != qst_pkg::QM_NONE;
    q_char  = (quote_mode == qst_pkg::QM_DOUBLE) ? qst_pkg::CH_DQUOTE : qst_pkg::CH_SQUOTE;
    is_q    = s_tdata == qst_pkg::CH_DQUOTE || s_tdata == qst_pkg::CH_SQUOTE;
    dropped = token_length >= qst_pkg::MAX_LEN;

    lead_v      = 1'b0;
    app_v       = 1'b0;
    trail_v     = 1'b0;
    lead_trunc  = overflowed;
    trail_trunc = 1'b0;

    quote_mode_next   = quote_mode;
    token_length_next = token_length;
    overflowed_next   = overflowed;

    if (s_tdata == qst_pkg::CH_NUL) begin
      lead_v            = token_length != '0;
      quote_mode_next   = qst_pkg::QM_NONE;
      token_length_next = '0;
      overflowed_next   = 1'b0;
    end else if (in_str) begin
      app_v = !dropped;
      if (s_tdata == q_char) begin
        // token is never empty here: it holds the opening quote or is already full
        trail_v           = 1'b1;
        trail_trunc       = overflowed || dropped;
        quote_mode_next   = qst_pkg::QM_NONE;
        token_length_next = '0;
        overflowed_next   = 1'b0;
      end else begin
        token_length_next = dropped ? token_length : token_length + 8'd1;
        overflowed_next   = overflowed || dropped;
      end
    end else if (s_tdata == qst_pkg::CH_LF || s_tdata == qst_pkg::CH_SPACE) begin
      lead_v            = token_length != '0;
      token_length_next = '0;
      overflowed_next   = 1'b0;
    end else if (qst_pkg::is_delim(s_tdata)) begin
      // after the leading close the token is empty, so the append always fits
      lead_v            = token_length != '0;
      app_v             = 1'b1;
      trail_v           = 1'b1;
      token_length_next = '0;
      overflowed_next   = 1'b0;
    end else begin
      if (is_q) begin
        quote_mode_next = (s_tdata == qst_pkg::CH_DQUOTE) ? qst_pkg::QM_DOUBLE
                                                          : qst_pkg::QM_SINGLE;
      end
      app_v             = !dropped;
      token_length_next = dropped ? token_length : token_length + 8'd1;
      overflowed_next   = overflowed || dropped;
    end

    for (int k = 0; k < 3; k++) begin
      ev[k] = '{kind: qst_pkg::KIND_CLOSE, ch_out: 8'd0, truncated: 1'b0, last: 1'b0};
    end
    pos = 2'd0;
    if (lead_v) begin
      ev[pos] = '{kind: qst_pkg::KIND_CLOSE, ch_out: 8'd0, truncated: lead_trunc,
                  last: 1'b0};
      pos = pos + 2'd1;
    end
    if (app_v) begin
      ev[pos] = '{kind: qst_pkg::KIND_APPEND, ch_out: s_tdata, truncated: 1'b0,
                  last: 1'b0};
      pos = pos + 2'd1;
    end
    if (trail_v) begin
      ev[pos] = '{kind: qst_pkg::KIND_CLOSE, ch_out: 8'd0, truncated: trail_trunc,
                  last: 1'b0};
      pos = pos + 2'd1;
    end
    n_ev = pos;
    if (pos != 2'd0) begin
      ev[pos - 2'd1].last = 1'b1;
    end
  end

  // queue: shift on pop, append new events behind what remains
  always_comb begin
    logic [qst_pkg::QCNT_W-1:0] base;
    base = count - (pop ? qst_pkg::QCNT_W'(1) : qst_pkg::QCNT_W'(0));
    for (int i = 0; i < qst_pkg::QDEPTH; i++) begin
      if (pop && i < qst_pkg::QDEPTH - 1) begin
        slots_next[i] = slots[i + 1];
      end else begin
        slots_next[i] = slots[i];
      end
      for (int k = 0; k < 3; k++) begin
        if (push && k < int'(n_ev) &&
            (base + qst_pkg::QCNT_W'(k)) == qst_pkg::QCNT_W'(i)) begin
          slots_next[i] = ev[k];
        end
      end
    end
    count_next = base + (push ? qst_pkg::QCNT_W'(n_ev) : qst_pkg::QCNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode   <= qst_pkg::QM_NONE;
      token_length <= '0;
      overflowed   <= 1'b0;
      count        <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        quote_mode   <= quote_mode_next;
        token_length <= token_length_next;
        overflowed   <= overflowed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < qst_pkg::QDEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qst_pkg::QCNT_W'(qst_pkg::QDEPTH))
    else $error("output queue overfilled");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> token_length == qst_pkg::MAX_LEN)
    else $error("overflow flag set on a token below the limit");

  a_nul_resets: assert property (@(posedge clk) disable iff (rst)
    (push && s_tdata == qst_pkg::CH_NUL) |=>
      (token_length == '0 && quote_mode == qst_pkg::QM_NONE && !overflowed))
    else $error("end of text did not return state to idle");

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // tokenizer state mirror
  qst_pkg::quote_mode_t qmode;
  logic [7:0]           tok_len;
  logic                 tok_over;

  qst_pkg::event_t      pending_events[$];

  int unsigned bytes_sent;
  int unsigned events_seen;
  int unsigned closes_seen;
  int unsigned trunc_seen;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned hold_cycles;
  bit          src_idle_on;
  bit          sink_stall_on;

  quoted_string_tokenizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic push_append(ref qst_pkg::event_t evs[$], input logic [7:0] c);
    if (tok_len < qst_pkg::MAX_LEN) begin
      tok_len++;
      evs.push_back(qst_pkg::event_t'{kind: qst_pkg::KIND_APPEND, ch_out: c,
                                      truncated: 1'b0, last: 1'b0});
    end else begin
      tok_over = 1'b1;
    end
  endtask

  task automatic push_close(ref qst_pkg::event_t evs[$]);
    if (tok_len != 8'd0) begin
      evs.push_back(qst_pkg::event_t'{kind: qst_pkg::KIND_CLOSE, ch_out: 8'd0,
                                      truncated: tok_over, last: 1'b0});
      tok_len  = 8'd0;
      tok_over = 1'b0;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] c);
    qst_pkg::event_t evs[$];
    logic [7:0]      closing_quote;
    if (c == qst_pkg::CH_NUL) begin
      push_close(evs);
      qmode    = qst_pkg::QM_NONE;
      tok_len  = 8'd0;
      tok_over = 1'b0;
    end else if (qmode != qst_pkg::QM_NONE) begin
      // the odd code behaves like a single-quoted string
      closing_quote = (qmode == qst_pkg::QM_DOUBLE) ? qst_pkg::CH_DQUOTE
                                                    : qst_pkg::CH_SQUOTE;
      push_append(evs, c);
      if (c == closing_quote) begin
        qmode = qst_pkg::QM_NONE;
        push_close(evs);
      end
    end else if (c == qst_pkg::CH_LF || c == qst_pkg::CH_SPACE) begin
      push_close(evs);
    end else if (qst_pkg::is_delim(c)) begin
      push_close(evs);
      push_append(evs, c);
      push_close(evs);
    end else if (c == qst_pkg::CH_DQUOTE || c == qst_pkg::CH_SQUOTE) begin
      qmode = (c == qst_pkg::CH_DQUOTE) ? qst_pkg::QM_DOUBLE : qst_pkg::QM_SINGLE;
      push_append(evs, c);
    end else begin
      push_append(evs, c);
    end
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  // ----------------------------------------------------------- byte pickers

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (qst_pkg::is_delim(c) || c == qst_pkg::CH_LF || c == qst_pkg::CH_SPACE ||
           c == qst_pkg::CH_DQUOTE || c == qst_pkg::CH_SQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] string_byte(input logic [7:0] quote);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == quote);
    return c;
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 10))
      0:       return qst_pkg::CH_TAB;
      1:       return qst_pkg::CH_LF;
      2:       return qst_pkg::CH_LPAREN;
      3:       return qst_pkg::CH_RPAREN;
      4:       return qst_pkg::CH_COMMA;
      5:       return qst_pkg::CH_COLON;
      6:       return qst_pkg::CH_LBRACK;
      7:       return qst_pkg::CH_RBRACK;
      8:       return qst_pkg::CH_LBRACE;
      9:       return qst_pkg::CH_RBRACE;
      default: return qst_pkg::CH_SPACE;
    endcase
  endfunction

  // ------------------------------------------------------------------ driver

  task automatic send_byte(input logic [7:0] c);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk);
    while (!s_tready);
    tokenize_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_word(input int unsigned len);
    repeat (len) send_byte(plain_byte());
  endtask

  task automatic send_random_text(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  q;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word($urandom_range(1, 8));
        send_byte(sep_byte());
      end else if (pick < 65) begin
        q = $urandom_range(0, 1) ? qst_pkg::CH_DQUOTE : qst_pkg::CH_SQUOTE;
        send_byte(q);
        repeat ($urandom_range(0, 8)) send_byte(string_byte(q));
        // now and then leave the string open
        if ($urandom_range(0, 9) != 0) send_byte(q);
      end else if (pick < 78) begin
        send_byte(sep_byte());
      end else if (pick < 85) begin
        send_byte(qst_pkg::CH_NUL);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int unsigned stall_left;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        m_tready   <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- checker

  task automatic note_mismatch(input string what, input qst_pkg::event_t want,
                               input qst_pkg::event_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR %0s @%0t: expected kind=%0d ch=%02h trunc=%0d last=%0d",
               what, $time, want.kind, want.ch_out, want.truncated, want.last);
      $display("  got kind=%0d ch=%02h trunc=%0d last=%0d",
               got.kind, got.ch_out, got.truncated, got.last);
    end
  endtask

  always @(posedge clk) begin : event_check
    qst_pkg::event_t got;
    qst_pkg::event_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = qst_pkg::event_t'{kind: m_tuser[0], ch_out: m_tdata, truncated: m_tuser[1],
                              last: m_tlast};
      events_seen++;
      if (got.kind == qst_pkg::KIND_CLOSE) closes_seen++;
      if (got.kind == qst_pkg::KIND_CLOSE && got.truncated) trunc_seen++;
      if (pending_events.size() == 0) begin
        note_mismatch("unexpected event", qst_pkg::event_t'('0), got);
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.ch_out !== want.ch_out ||
            got.truncated !== want.truncated || got.last !== want.last)
          note_mismatch("event mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles, %0d events outstanding",
               quiet_cycles, pending_events.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------- tests

  task automatic test_delimiters();
    send_text("a\tb(),:[]{}  \nx\ncd,");
    send_byte(qst_pkg::CH_SPACE);
  endtask

  task automatic test_quoted_strings();
    send_text("\"a '\"q'z \"w\"y\" ");
    send_text("'a\"b c' ");
    // zero byte inside an open string closes it
    send_text("\"k");
    send_byte(qst_pkg::CH_NUL);
    send_byte(qst_pkg::CH_NUL);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(qst_pkg::CH_NUL);
  endtask

  task automatic test_token_limit();
    // fill the token to the limit; the quotes past it are dropped but still
    // open and close string mode, and the close comes out truncated
    send_word(qst_pkg::MAX_TOKEN_LEN);
    send_text("\"x\"");
    send_byte(qst_pkg::CH_LBRACE);
  endtask

  task automatic test_random_text();
    send_random_text(80);
  endtask

  task automatic test_backpressure();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    hold_cycles   = 80;
    repeat (12) begin
      send_byte(plain_byte());
      send_byte(sep_byte());
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    send_random_text(40);
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = 8'd0;
    qmode         = qst_pkg::QM_NONE;
    tok_len       = 8'd0;
    tok_over      = 1'b0;
    bytes_sent    = 0;
    events_seen   = 0;
    closes_seen   = 0;
    trunc_seen    = 0;
    err_count     = 0;
    quiet_cycles  = 0;
    hold_cycles   = 0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_delimiters();
    test_quoted_strings();
    test_token_limit();
    test_random_text();
    test_backpressure();
    test_steady_stream();

    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tokenizer: %0d bytes in, %0d events checked (%0d closes, %0d truncated)",
             bytes_sent, events_seen, closes_seen, trunc_seen);
    $display("covered delimiters, strings, length limit, end of text, long stall; %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
